>>> rtl/first_fit_extent_allocator_core_assert.svh
// Assertion macros for the extent allocator checker.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_CORE_ASSERT_SVH

// Clocked assertion, masked during reset.
`define FFEA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define FFEA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/ffea_pkg.sv
// Shared constants, codes and types for the extent allocator.
package ffea_pkg;

    localparam int MAX_PARTITIONS = 32;
    localparam int RANGE_DEPTH    = MAX_PARTITIONS + 2;
    localparam int IDX_W          = $clog2(RANGE_DEPTH + 1);

    localparam int BS_W    = 17;
    localparam int BLK_W   = 48;
    localparam int SIZE_W  = 60;
    localparam int END_W   = 64;
    localparam int STAT_W  = 3;
    localparam int META_W  = 15;
    localparam int CFG_IDX_W = 8;

    localparam int RESERVED_BYTES = 16 * 1024;

    localparam logic [STAT_W-1:0] ST_PLACED     = 3'd0;
    localparam logic [STAT_W-1:0] ST_SKIPPED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_MISALIGNED = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BEYOND     = 3'd4;
    localparam logic [STAT_W-1:0] ST_IGNORED    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 8'd1;

    typedef struct packed {
        logic load_new;
        logic load_left;
    } cell_ctrl_t;

endpackage

>>> rtl/ffea_divider.sv
// Restoring divider, one quotient bit per cycle.
module ffea_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ffea_pkg::SIZE_W-1:0]  dividend,
    input  logic [ffea_pkg::BS_W-1:0]    divisor,
    output logic                         done,
    output logic [ffea_pkg::SIZE_W-1:0]  quotient,
    output logic [ffea_pkg::BS_W-1:0]    remainder
);
    import ffea_pkg::*;

    localparam int CNT_W = $clog2(SIZE_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SIZE_W-1:0]  quo_reg, quo_next;
    logic [BS_W-1:0]    rem_reg, rem_next;
    logic [BS_W:0]      trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[SIZE_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SIZE_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[SIZE_W-2:0], fits};
            rem_next = fits ? BS_W'(trial - {1'b0, divisor}) : trial[BS_W-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/ffea_cell.sv
// One range of the list: holds start and end, shifts from its left neighbor.
module ffea_cell (
    input  logic                         aclk,
    input  ffea_pkg::cell_ctrl_t         ctrl,
    input  logic [ffea_pkg::BLK_W-1:0]   wr_start,
    input  logic [ffea_pkg::END_W-1:0]   wr_end,
    input  logic [ffea_pkg::BLK_W-1:0]   left_start,
    input  logic [ffea_pkg::END_W-1:0]   left_end,
    input  logic                         fit_mode,
    input  logic [ffea_pkg::BLK_W-1:0]   key_start,
    input  logic [ffea_pkg::SIZE_W-1:0]  key_blocks,
    output logic [ffea_pkg::BLK_W-1:0]   start_q,
    output logic [ffea_pkg::END_W-1:0]   end_q,
    output logic                         hit
);
    import ffea_pkg::*;

    logic [BLK_W-1:0] start_reg;
    logic [END_W-1:0] end_reg;
    logic [END_W-1:0] gap;

    assign gap = {{(END_W-BLK_W){1'b0}}, start_reg} - left_end;
    assign hit = fit_mode ? (gap >= {{(END_W-SIZE_W){1'b0}}, key_blocks})
                          : (start_reg >= key_start);

    always_ff @(posedge aclk) begin
        if (ctrl.load_new) begin
            start_reg <= wr_start;
            end_reg   <= wr_end;
        end else if (ctrl.load_left) begin
            start_reg <= left_start;
            end_reg   <= left_end;
        end
    end

    assign start_q = start_reg;
    assign end_q   = end_reg;

endmodule

>>> rtl/first_fit_extent_allocator_core.sv
// Extent allocator top: takes one request at a time (s_ready is high only while idle) and
// returns one result transaction per request. A request that scans the list divides its
// byte size by the block size, visits the ranges in order, and inserts a range when placed.
// A first-of-set request first rebuilds the two reserved ranges: a division for the
// metadata size plus two writes.
// The list is a row of 34 range cells that shift right together on insert.
module first_fit_extent_allocator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ffea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffea_pkg::BLK_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_first_of_set,
    input  logic [ffea_pkg::SIZE_W-1:0]     s_size_bytes,
    input  logic [ffea_pkg::BLK_W-1:0]      s_start_block,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ffea_pkg::STAT_W-1:0]     m_status,
    output logic [ffea_pkg::BLK_W-1:0]      m_placed_start,
    output logic [ffea_pkg::BLK_W-1:0]      m_placed_blocks
);
    import ffea_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_META  = 4'd1;
    localparam logic [3:0] S_METAW = 4'd2;
    localparam logic [3:0] S_REB0  = 4'd3;
    localparam logic [3:0] S_REB1  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_DIVW  = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_INS   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [BS_W-1:0]   bs_reg;
    logic [BLK_W-1:0]  bc_reg;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic              failed_reg, failed_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [SIZE_W-1:0] size_reg;
    logic [BLK_W-1:0]  key_reg;
    logic [SIZE_W-1:0] nb_reg, nb_next;
    logic [META_W-1:0] meta_reg, meta_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic [BLK_W-1:0]  res_start_reg, res_start_next;
    logic [BLK_W-1:0]  res_blocks_reg, res_blocks_next;
    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [BLK_W-1:0]  m_start_reg, m_blocks_reg;

    logic [BS_W-1:0]   eff_bs;
    logic              div_start, div_done;
    logic [SIZE_W-1:0] div_dividend, div_quo;
    logic [BS_W-1:0]   div_rem;
    logic              fit_mode;
    logic              out_load;

    logic [BLK_W-1:0]  wr_start;
    logic [END_W-1:0]  wr_end;
    logic [END_W-1:0]  left_end_sel;
    logic [END_W-1:0]  base;
    logic [IDX_W-1:0]  ins_pos;
    logic              ins_en;

    cell_ctrl_t        ctrl  [RANGE_DEPTH];
    logic [BLK_W-1:0]  c_start [RANGE_DEPTH];
    logic [END_W-1:0]  c_end   [RANGE_DEPTH];
    logic [RANGE_DEPTH-1:0] c_hit;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign eff_bs    = (bs_reg == '0) ? BS_W'(1) : bs_reg;
    assign fit_mode  = (key_reg == '0);
    assign out_load  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_reg <= BS_W'(512);
            bc_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BLOCK_SIZE:  bs_reg <= cfg_data[BS_W-1:0];
                REG_BLOCK_COUNT: bc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ffea_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_bs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        left_end_sel = '0;
        for (int i = 0; i < RANGE_DEPTH - 1; i++) begin
            if (k_reg == IDX_W'(i + 1)) left_end_sel = left_end_sel | c_end[i];
        end
    end

    assign base = fit_mode ? left_end_sel : {{(END_W-BLK_W){1'b0}}, key_reg};

    always_comb begin
        wr_start = '0;
        wr_end   = '0;
        ins_pos  = '0;
        ins_en   = 1'b0;
        unique case (state_reg)
            S_REB0: begin
                wr_end = {{(END_W-META_W){1'b0}}, meta_reg};
                ins_en = 1'b1;
            end
            S_REB1: begin
                wr_start = BLK_W'({{(END_W-BLK_W){1'b0}}, bc_reg}
                                  - {{(END_W-META_W){1'b0}}, meta_reg});
                wr_end   = {{(END_W-BLK_W){1'b0}}, bc_reg};
                ins_pos  = IDX_W'(1);
                ins_en   = 1'b1;
            end
            S_INS: begin
                wr_start = base[BLK_W-1:0];
                wr_end   = base + {{(END_W-SIZE_W){1'b0}}, nb_reg};
                ins_pos  = k_reg;
                ins_en   = 1'b1;
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < RANGE_DEPTH; g++) begin : g_cell
        logic [BLK_W-1:0] l_start;
        logic [END_W-1:0] l_end;
        if (g == 0) begin : g_head
            assign l_start = '0;
            assign l_end   = '0;
        end else begin : g_body
            assign l_start = c_start[g-1];
            assign l_end   = c_end[g-1];
        end
        assign ctrl[g].load_new  = ins_en && (ins_pos == IDX_W'(g));
        assign ctrl[g].load_left = (state_reg == S_INS) && (IDX_W'(g) > k_reg)
                                   && (IDX_W'(g) <= count_reg);
        ffea_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl[g]),
            .wr_start   (wr_start),
            .wr_end     (wr_end),
            .left_start (l_start),
            .left_end   (l_end),
            .fit_mode   (fit_mode),
            .key_start  (key_reg),
            .key_blocks (nb_reg),
            .start_q    (c_start[g]),
            .end_q      (c_end[g]),
            .hit        (c_hit[g])
        );
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        failed_next     = failed_reg;
        k_next          = k_reg;
        nb_next         = nb_reg;
        meta_next       = meta_reg;
        res_stat_next   = res_stat_reg;
        res_start_next  = res_start_reg;
        res_blocks_next = res_blocks_reg;
        div_start       = 1'b0;
        div_dividend    = size_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = s_first_of_set ? S_META : S_CHK;
            end
            S_META: begin
                div_start    = 1'b1;
                div_dividend = SIZE_W'(RESERVED_BYTES) + SIZE_W'({eff_bs, 1'b0});
                state_next   = S_METAW;
            end
            S_METAW: begin
                if (div_done) begin
                    meta_next  = div_quo[META_W-1:0];
                    state_next = S_REB0;
                end
            end
            S_REB0: state_next = S_REB1;
            S_REB1: begin
                count_next  = IDX_W'(2);
                failed_next = 1'b0;
                state_next  = S_CHK;
            end
            S_CHK: begin
                res_start_next  = '0;
                res_blocks_next = '0;
                if (failed_reg) begin
                    res_stat_next = ST_IGNORED;
                    state_next    = S_OUT;
                end else if (size_reg == '0) begin
                    res_stat_next = ST_SKIPPED;
                    state_next    = S_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    if (div_rem != '0) begin
                        res_stat_next = ST_MISALIGNED;
                        failed_next   = 1'b1;
                        state_next    = S_OUT;
                    end else begin
                        nb_next    = div_quo;
                        k_next     = fit_mode ? IDX_W'(1) : '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (k_reg >= count_reg) begin
                    res_stat_next = fit_mode ? ST_NO_SPACE : ST_BEYOND;
                    failed_next   = 1'b1;
                    state_next    = S_OUT;
                end else if (c_hit[k_reg[IDX_W-1:0]]) begin
                    if (count_reg >= IDX_W'(RANGE_DEPTH)) begin
                        res_stat_next = ST_NO_SPACE;
                        failed_next   = 1'b1;
                        state_next    = S_OUT;
                    end else begin
                        state_next = S_INS;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_INS: begin
                res_stat_next   = ST_PLACED;
                res_start_next  = base[BLK_W-1:0];
                res_blocks_next = nb_reg[BLK_W-1:0];
                count_next      = count_reg + 1'b1;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            failed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            failed_reg <= failed_next;
            if (state_reg == S_OUT && out_load) m_valid_reg <= 1'b1;
            else if (m_ready)                   m_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            size_reg  <= s_size_bytes;
            key_reg   <= s_start_block;
        end
        if (state_reg == S_OUT && out_load) begin
            m_status_reg <= res_stat_reg;
            m_start_reg  <= res_start_reg;
            m_blocks_reg <= res_blocks_reg;
        end
        k_reg          <= k_next;
        nb_reg         <= nb_next;
        meta_reg       <= meta_next;
        res_stat_reg   <= res_stat_next;
        res_start_reg  <= res_start_next;
        res_blocks_reg <= res_blocks_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_placed_start  = m_start_reg;
    assign m_placed_blocks = m_blocks_reg;

endmodule

>>> rtl/ffea_checker.sv
// Port-level checker for the extent allocator, bound to the top level.
`include "first_fit_extent_allocator_core_assert.svh"

module ffea_port_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ffea_pkg::STAT_W-1:0]   m_status,
    input logic [ffea_pkg::BLK_W-1:0]    m_placed_start,
    input logic [ffea_pkg::BLK_W-1:0]    m_placed_blocks
);
    import ffea_pkg::*;

    `FFEA_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `FFEA_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready, "second transaction taken early")
    `FFEA_ASSERT(a_fail_zero, m_valid && (m_status != ST_PLACED) |-> (m_placed_start == '0) && (m_placed_blocks == '0), "nonzero extent on unplaced result")
    `FFEA_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind first_fit_extent_allocator_core ffea_port_checker u_ffea_checker (.*);
